FILE: rtl/gep_pkg.sv
// Shared types, constants and setup functions for the gamepad edge and dead zone block.
// Has no dependencies. Used by gep_lane, gep_merge and gamepad_edge_and_deadzone.
package gep_pkg;

  localparam int NumLanes = 6;
  localparam int QuoW     = 16;
  localparam int LvlW     = 17;
  localparam int DivSteps = 16;
  localparam int CntW     = $clog2(DivSteps);

  localparam int LaneLt = 0;
  localparam int LaneRt = 1;
  localparam int LaneLx = 2;
  localparam int LaneLy = 3;
  localparam int LaneRx = 4;
  localparam int LaneRy = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } gep_state_e;

  typedef enum logic [1:0] {
    OP_KEEP,
    OP_UPDATE,
    OP_LOST
  } gep_op_e;

  typedef enum logic [1:0] {
    CFG_LEFT_DZ,
    CFG_RIGHT_DZ,
    CFG_TRIG_THR
  } gep_cfg_e;

  typedef struct packed {
    logic            zero;
    logic            neg;
    logic [QuoW-1:0] num;
    logic [QuoW-1:0] den;
  } gep_div_t;

  function automatic gep_div_t trig_prep(logic [7:0] raw, logic [7:0] thr);
    gep_div_t r;
    r.zero = (raw <= thr);
    r.neg  = 1'b0;
    r.num  = {8'd0, 8'(raw - thr)};
    r.den  = {8'd0, 8'(8'd255 - thr)};
    return r;
  endfunction

  function automatic gep_div_t thumb_prep(logic signed [15:0] raw, logic [14:0] dz);
    gep_div_t          r;
    logic signed [17:0] v;
    logic signed [17:0] p;
    v = {{2{raw[15]}}, raw};
    p = {3'b000, dz};
    r.zero = 1'b0;
    r.neg  = 1'b0;
    r.num  = '0;
    r.den  = '0;
    if (v > p) begin
      r.num = 16'(v - p);
      r.den = 16'(17'd32767 - {2'b00, dz});
    end else if (v < -p) begin
      r.neg = 1'b1;
      r.num = 16'(-v - p);
      r.den = 16'(17'd32768 - {2'b00, dz});
    end else begin
      r.zero = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/gep_lane.sv
// One scaling lane: restoring divider giving floor(num * 32768 / den), one bit per cycle.
// Depends on gep_pkg for the setup struct and divider constants.
module gep_lane
  import gep_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  gep_div_t               div_i,
  output logic                   busy_o,
  output logic signed [LvlW-1:0] level_o
);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [QuoW:0]   rem_q, rem_d;
  logic [QuoW-1:0] den_q, den_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic            zero_q, zero_d;
  logic            neg_q, neg_d;
  logic [QuoW:0]   shifted;
  logic            ge;
  logic [LvlW-1:0] mag;

  always_comb begin
    shifted = (cnt_q == '0) ? rem_q : {rem_q[QuoW-1:0], 1'b0};
    ge      = (shifted >= {1'b0, den_q});
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    zero_d  = zero_q;
    neg_d   = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, div_i.num};
      den_d  = div_i.den;
      quo_d  = '0;
      zero_d = div_i.zero;
      neg_d  = div_i.neg;
    end else if (busy_q) begin
      rem_d = ge ? (shifted - {1'b0, den_q}) : shifted;
      quo_d = {quo_q[QuoW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    zero_q <= zero_d;
    neg_q  <= neg_d;
  end

  assign mag     = {1'b0, quo_q};
  assign busy_o  = busy_q;
  assign level_o = zero_q ? '0 : (neg_q ? -$signed(mag) : $signed(mag));

endmodule

FILE: rtl/gep_merge.sv
// Merge stage: holds connection, packet number, button flags and axis levels.
// Depends on gep_pkg; takes lane levels and gives the next state to the output register.
module gep_merge
  import gep_pkg::*;
#(
  parameter int NumButtons = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               commit_i,
  input  gep_op_e                            op_i,
  input  logic [31:0]                        seq_i,
  input  logic [NumButtons-1:0]              mask_i,
  input  logic [NumLanes-1:0][LvlW-1:0]      lvl_i,
  output logic [31:0]                        last_seq_o,
  output logic                               conn_o,
  output logic [NumButtons-1:0]              held_o,
  output logic [NumButtons-1:0]              press_o,
  output logic [NumButtons-1:0]              release_o,
  output logic [NumLanes-1:0][LvlW-1:0]      lvl_o
);

  logic [31:0]                   last_seq_q, last_seq_d;
  logic                          conn_q, conn_d;
  logic [NumButtons-1:0]         held_q, held_d;
  logic [NumButtons-1:0]         press_q, press_d;
  logic [NumButtons-1:0]         release_q, release_d;
  logic [NumLanes-1:0][LvlW-1:0] lvl_q, lvl_d;

  always_comb begin
    last_seq_d = last_seq_q;
    conn_d     = conn_q;
    held_d     = held_q;
    press_d    = press_q;
    release_d  = release_q;
    lvl_d      = lvl_q;
    unique case (op_i)
      OP_UPDATE: begin
        conn_d     = 1'b1;
        last_seq_d = seq_i;
        press_d    = mask_i & ~held_q;
        release_d  = held_q & ~mask_i;
        held_d     = mask_i;
        lvl_d      = lvl_i;
      end
      OP_LOST: begin
        conn_d    = 1'b0;
        held_d    = '0;
        press_d   = '0;
        release_d = '0;
        lvl_d     = '0;
      end
      default: begin
        conn_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= '1;
      conn_q     <= 1'b0;
      held_q     <= '0;
      press_q    <= '0;
      release_q  <= '0;
      lvl_q      <= '0;
    end else if (commit_i) begin
      last_seq_q <= last_seq_d;
      conn_q     <= conn_d;
      held_q     <= held_d;
      press_q    <= press_d;
      release_q  <= release_d;
      lvl_q      <= lvl_d;
    end
  end

  assign last_seq_o = last_seq_q;
  assign conn_o     = conn_d;
  assign held_o     = held_d;
  assign press_o    = press_d;
  assign release_o  = release_d;
  assign lvl_o      = lvl_d;

endmodule

FILE: rtl/gamepad_edge_and_deadzone.sv
// Top level of the gamepad edge and dead zone block: config registers, control, output register.
// Depends on gep_pkg, gep_lane (six scaling lanes) and gep_merge.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid / tready        tuser poll_ok, tdata poll fields
//   m_axis    out  tvalid / tready        tuser is_connected, tdata levels and flags
//   cfg       in   cfg_we_i (no stall)    cfg_addr_i, cfg_wdata_i
//
// A poll with a new packet number loads the lanes when it is accepted, then runs the
// one-bit-per-cycle divider in each lane, sees the lanes idle and commits.
// Any other poll goes straight to commit. Reset empties the output register and loads register defaults.
// The next poll is accepted once the previous one is committed; a stalled result is held
// in the output register while the next poll runs.
module gamepad_edge_and_deadzone
  import gep_pkg::*;
#(
  parameter int NumButtons = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_addr_i,
  input  logic [14:0]                    cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // packet_seq, button_mask, left_trigger_raw, right_trigger_raw,
  // left_x_raw, left_y_raw, right_x_raw, right_y_raw, zero fill
  input  logic [((NumButtons+119)/8)*8-1:0] s_axis_tdata,
  // poll_ok
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // held_flags, press_edges, release_edges, left_trigger_level, right_trigger_level,
  // left_x_level, left_y_level, right_x_level, right_y_level, zero fill
  output logic [((3*NumButtons+107)/8)*8-1:0] m_axis_tdata,
  // is_connected
  output logic                           m_axis_tuser
);

  localparam int InMaskLo  = 32;
  localparam int InLtLo    = InMaskLo + NumButtons;
  localparam int InRtLo    = InLtLo + 8;
  localparam int InLxLo    = InRtLo + 8;
  localparam int InLyLo    = InLxLo + 16;
  localparam int InRxLo    = InLyLo + 16;
  localparam int InRyLo    = InRxLo + 16;
  localparam int OutPressLo = NumButtons;
  localparam int OutRelLo   = 2 * NumButtons;
  localparam int OutLtLo    = 3 * NumButtons;
  localparam int OutRtLo    = OutLtLo + 16;
  localparam int OutLxLo    = OutRtLo + 16;

  logic [14:0] left_dz_q;
  logic [14:0] right_dz_q;
  logic [7:0]  trig_thr_q;

  gep_state_e state_q, state_d;
  gep_op_e    op_q, op_d, in_op;
  logic [31:0]           seq_q;
  logic [NumButtons-1:0] mask_q;
  logic                  accept, start, commit;

  gep_div_t                      lane_div [NumLanes];
  logic [NumLanes-1:0]           lane_busy;
  logic [NumLanes-1:0][LvlW-1:0] lane_lvl;

  logic [31:0]                   last_seq;
  logic                          nx_conn;
  logic [NumButtons-1:0]         nx_held, nx_press, nx_release;
  logic [NumLanes-1:0][LvlW-1:0] nx_lvl;

  logic                          m_valid_q, m_valid_d;
  logic                          out_conn_q;
  logic [NumButtons-1:0]         out_held_q, out_press_q, out_release_q;
  logic [NumLanes-1:0][LvlW-1:0] out_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_dz_q  <= 15'd7849;
      right_dz_q <= 15'd8689;
      trig_thr_q <= 8'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_LEFT_DZ:  left_dz_q  <= cfg_wdata_i;
        CFG_RIGHT_DZ: right_dz_q <= cfg_wdata_i;
        CFG_TRIG_THR: trig_thr_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_op = !s_axis_tuser ? OP_LOST :
                 (s_axis_tdata[31:0] != last_seq) ? OP_UPDATE : OP_KEEP;

  assign lane_div[LaneLt] = trig_prep(s_axis_tdata[InLtLo +: 8], trig_thr_q);
  assign lane_div[LaneRt] = trig_prep(s_axis_tdata[InRtLo +: 8], trig_thr_q);
  assign lane_div[LaneLx] = thumb_prep(s_axis_tdata[InLxLo +: 16], left_dz_q);
  assign lane_div[LaneLy] = thumb_prep(s_axis_tdata[InLyLo +: 16], left_dz_q);
  assign lane_div[LaneRx] = thumb_prep(s_axis_tdata[InRxLo +: 16], right_dz_q);
  assign lane_div[LaneRy] = thumb_prep(s_axis_tdata[InRyLo +: 16], right_dz_q);

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    s_axis_tready = 1'b0;
    accept        = 1'b0;
    start         = 1'b0;
    commit        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          accept = 1'b1;
          op_d   = in_op;
          if (in_op == OP_UPDATE) begin
            start   = 1'b1;
            state_d = ST_RUN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_RUN: begin
        if (lane_busy == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_KEEP;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q  <= s_axis_tdata[31:0];
      mask_q <= s_axis_tdata[InMaskLo +: NumButtons];
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    gep_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start),
      .div_i   (lane_div[g]),
      .busy_o  (lane_busy[g]),
      .level_o (lane_lvl[g])
    );
  end

  gep_merge #(
    .NumButtons (NumButtons)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .commit_i   (commit),
    .op_i       (op_q),
    .seq_i      (seq_q),
    .mask_i     (mask_q),
    .lvl_i      (lane_lvl),
    .last_seq_o (last_seq),
    .conn_o     (nx_conn),
    .held_o     (nx_held),
    .press_o    (nx_press),
    .release_o  (nx_release),
    .lvl_o      (nx_lvl)
  );

  assign m_valid_d = commit ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_conn_q    <= nx_conn;
      out_held_q    <= nx_held;
      out_press_q   <= nx_press;
      out_release_q <= nx_release;
      out_lvl_q     <= nx_lvl;
    end
  end

  always_comb begin
    m_axis_tdata                             = '0;
    m_axis_tdata[0 +: NumButtons]            = out_held_q;
    m_axis_tdata[OutPressLo +: NumButtons]   = out_press_q;
    m_axis_tdata[OutRelLo +: NumButtons]     = out_release_q;
    m_axis_tdata[OutLtLo +: 16]              = out_lvl_q[LaneLt][15:0];
    m_axis_tdata[OutRtLo +: 16]              = out_lvl_q[LaneRt][15:0];
    m_axis_tdata[OutLxLo +: LvlW]            = out_lvl_q[LaneLx];
    m_axis_tdata[OutLxLo + LvlW +: LvlW]     = out_lvl_q[LaneLy];
    m_axis_tdata[OutLxLo + 2 * LvlW +: LvlW] = out_lvl_q[LaneRx];
    m_axis_tdata[OutLxLo + 3 * LvlW +: LvlW] = out_lvl_q[LaneRy];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_conn_q;

endmodule
